@@ sv/tpcm_pkg.sv @@
// Shared types and constants for the touch point calibration mapper.
`timescale 1ns / 1ps

package tpcm_pkg;

  // Field widths of the sample and result transactions.
  localparam int RAW_W = 12;
  localparam int OUT_W = 13;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAL_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y     = 3'd7;

  // Reset value of both span registers.
  localparam logic [RAW_W-1:0] SPAN_RESET = 12'hFFF;

  // Default screen resolution.
  localparam int HORIZ_RES_DEF = 480;
  localparam int VERT_RES_DEF  = 320;

  // Significant bits of the touch controller reading.
  localparam int RAW_BITS = 12;
  localparam logic [RAW_W-1:0] RAW_MASK =
    (RAW_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((1 << RAW_BITS) - 1);

  // Saturation limits of a screen coordinate.
  localparam int OUT_MAX = 4095;
  localparam int OUT_MIN = -4096;

  // Control from the top level to one axis lane.
  typedef struct packed {
    logic start;
    logic mirror;
  } lane_ctrl_t;

  // Status from one axis lane back to the top level.
  typedef struct packed {
    logic busy;
    logic span_zero;
  } lane_stat_t;

endpackage

@@ sv/touch_point_calibrate_map.sv @@
// Top level of the touch point calibration mapper.
// Usage:
//   A raw touch sample is one transaction on the input channel (in_valid, in_stall);
//   each sample gives exactly one result transaction on the output channel
//   (out_valid, out_stall) carrying the held screen point, the pressed state and
//   the span error flag. The block works on one sample at a time and stalls the
//   input until the sample's result is loaded into the output register.
//   A calibrated down or move sample runs both axes in parallel through a
//   multiply and a bit-serial restoring divider, one quotient bit per cycle;
//   the next sample is taken only once the result has loaded and the sequencer
//   is back in idle. Every other sample skips the lanes and goes straight to
//   the finishing state.
//   The output register is the held state itself; while the receiver stalls, the
//   result stays unchanged and a finished next sample waits before loading it.
//   Reset clears the held point to zero, releases the pen, empties the output and
//   loads the register reset values (spans 4095, everything else 0).
//   Configuration registers are written through cfg_we, cfg_index and cfg_data
//   with no wait; the user must write them only while the block is idle (not enforced).
`timescale 1ns / 1ps

module touch_point_calibrate_map #(
  parameter int HORIZ_RES = tpcm_pkg::HORIZ_RES_DEF,
  parameter int VERT_RES  = tpcm_pkg::VERT_RES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic        [tpcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [tpcm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   sample_ok,
  input  logic        [tpcm_pkg::RAW_W-1:0]      raw_x,
  input  logic        [tpcm_pkg::RAW_W-1:0]      raw_y,
  input  logic                                   pen_down,
  input  logic                                   pen_move,
  input  logic                                   pen_up,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tpcm_pkg::OUT_W-1:0]      screen_x,
  output logic signed [tpcm_pkg::OUT_W-1:0]      screen_y,
  output logic                                   pressed,
  output logic                                   span_error
);
  import tpcm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAP,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_RAW,
    ACT_UP,
    ACT_MAP
  } act_t;

  state_t            state;
  act_t              act;
  logic [RAW_W-1:0]  rx_r;
  logic [RAW_W-1:0]  ry_r;

  // Configuration registers.
  logic              cal_enable;
  logic              swap_axes;
  logic              mirror_x;
  logic              mirror_y;
  logic [RAW_W-1:0]  offset_x;
  logic [RAW_W-1:0]  offset_y;
  logic [RAW_W-1:0]  span_x;
  logic [RAW_W-1:0]  span_y;

  logic [RAW_W-1:0]  rx_m;
  logic [RAW_W-1:0]  ry_m;
  logic              in_take;
  logic              point_set;
  act_t              act_next;
  logic              out_free;
  logic              out_load;

  lane_ctrl_t        ctrl_x;
  lane_ctrl_t        ctrl_y;
  lane_stat_t        stat_x;
  lane_stat_t        stat_y;
  logic signed [OUT_W-1:0] value_x;
  logic signed [OUT_W-1:0] value_y;

  // Input decode.
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign rx_m      = raw_x & RAW_MASK;
  assign ry_m      = raw_y & RAW_MASK;
  assign point_set = sample_ok && (pen_down || pen_move);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_FIN) && out_free;

  always_comb begin
    priority if (point_set && cal_enable) begin
      act_next = ACT_MAP;
    end else if (point_set) begin
      act_next = ACT_RAW;
    end else if (sample_ok && pen_up) begin
      act_next = ACT_UP;
    end else begin
      act_next = ACT_HOLD;
    end
  end

  // Lane starts on the accepting edge, with the axes already swapped if asked.
  assign ctrl_x.start  = in_take && (act_next == ACT_MAP);
  assign ctrl_x.mirror = mirror_x;
  assign ctrl_y.start  = in_take && (act_next == ACT_MAP);
  assign ctrl_y.mirror = mirror_y;

  tpcm_lane #(
    .RES (HORIZ_RES)
  ) u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl_x),
    .raw_a  (swap_axes ? ry_m : rx_m),
    .offset (offset_x),
    .span   (span_x),
    .stat   (stat_x),
    .value  (value_x)
  );

  tpcm_lane #(
    .RES (VERT_RES)
  ) u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl_y),
    .raw_a  (swap_axes ? rx_m : ry_m),
    .offset (offset_y),
    .span   (span_y),
    .stat   (stat_y),
    .value  (value_y)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_enable <= 1'b0;
      swap_axes  <= 1'b0;
      mirror_x   <= 1'b0;
      mirror_y   <= 1'b0;
      offset_x   <= '0;
      offset_y   <= '0;
      span_x     <= SPAN_RESET;
      span_y     <= SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_ENABLE: cal_enable <= cfg_data[0];
        REG_SWAP_AXES:  swap_axes  <= cfg_data[0];
        REG_MIRROR_X:   mirror_x   <= cfg_data[0];
        REG_MIRROR_Y:   mirror_y   <= cfg_data[0];
        REG_OFFSET_X:   offset_x   <= cfg_data[RAW_W-1:0];
        REG_OFFSET_Y:   offset_y   <= cfg_data[RAW_W-1:0];
        REG_SPAN_X:     span_x     <= cfg_data[RAW_W-1:0];
        REG_SPAN_Y:     span_y     <= cfg_data[RAW_W-1:0];
      endcase
    end
  end

  // Sequencer, held state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      screen_x   <= '0;
      screen_y   <= '0;
      pressed    <= 1'b0;
      span_error <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            act  <= act_next;
            rx_r <= rx_m;
            ry_r <= ry_m;
            state <= (act_next == ACT_MAP) ? S_MAP : S_FIN;
          end
        end
        S_MAP: begin
          if (!stat_x.busy && !stat_y.busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            unique case (act)
              ACT_MAP: begin
                screen_x   <= value_x;
                screen_y   <= value_y;
                pressed    <= 1'b1;
                span_error <= stat_x.span_zero || stat_y.span_zero;
              end
              ACT_RAW: begin
                screen_x   <= $signed({1'b0, rx_r});
                screen_y   <= $signed({1'b0, ry_r});
                pressed    <= 1'b1;
                span_error <= 1'b0;
              end
              ACT_UP: begin
                pressed    <= 1'b0;
                span_error <= 1'b0;
              end
              ACT_HOLD: begin
                span_error <= 1'b0;
              end
            endcase
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The lanes only work while the sequencer waits on them.
  a_lanes_in_map: assert property (@(posedge clk) disable iff (rst)
    (state != S_MAP) |-> (!stat_x.busy && !stat_y.busy))
    else $error("axis lane busy outside the mapping state");

  // No new sample is taken while a lane is still working on the previous one.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (stat_x.busy || stat_y.busy) |-> in_stall)
    else $error("sample accepted while lanes busy");

  // A span error only comes from a mapped point, which always presses.
  a_err_pressed: assert property (@(posedge clk) disable iff (rst)
    span_error |-> pressed)
    else $error("span error without pressed state");

  // A result is loaded only when the previous one has left or is leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(screen_x) && $stable(screen_y))
    else $error("stalled result overwritten");

endmodule

@@ sv/tpcm_lane.sv @@
// One axis of the calibration mapper: offset, scale, bit-serial divide, mirror, saturate.
`timescale 1ns / 1ps

module tpcm_lane #(
  parameter int RES = tpcm_pkg::HORIZ_RES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tpcm_pkg::lane_ctrl_t                ctrl,
  input  logic        [tpcm_pkg::RAW_W-1:0]   raw_a,
  input  logic        [tpcm_pkg::RAW_W-1:0]   offset,
  input  logic        [tpcm_pkg::RAW_W-1:0]   span,
  output tpcm_pkg::lane_stat_t                stat,
  output logic signed [tpcm_pkg::OUT_W-1:0]   value
);
  import tpcm_pkg::*;

  // Magnitude of the scaled offset reading, and the width that holds it signed and mirrored.
  localparam int MAG_W = RAW_W + $clog2(RES + 1);
  localparam int FW    = MAG_W + 2;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic signed [FW-1:0] RES_F = FW'(RES);
  localparam logic signed [FW-1:0] SAT_HI = FW'(OUT_MAX);
  localparam logic signed [FW-1:0] SAT_LO = FW'(OUT_MIN);

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIX,
    L_SAT
  } lane_state_t;

  lane_state_t             state;
  logic signed [RAW_W:0]   diff;
  logic [RAW_W-1:0]        span_r;
  logic                    mirror_r;
  logic                    neg;
  logic [MAG_W-1:0]        dvd;
  logic [RAW_W:0]          rem;
  logic [CNT_W-1:0]        cnt;
  logic signed [FW-1:0]    fix;
  logic                    span_zero;

  logic [RAW_W:0]          diff_abs;
  logic [RAW_W:0]          rem_sh;
  logic                    ge;
  logic [RAW_W:0]          rem_next;
  logic signed [FW-1:0]    q_mag;
  logic signed [FW-1:0]    q_signed;

  // Magnitude of the offset-corrected reading.
  assign diff_abs = diff[RAW_W] ? (RAW_W + 1)'(-diff) : diff;

  // One restoring division step: bring down the next dividend bit and try the span.
  assign rem_sh   = {rem[RAW_W-1:0], dvd[MAG_W-1]};
  assign ge       = rem_sh >= {1'b0, span_r};
  assign rem_next = ge ? (rem_sh - {1'b0, span_r}) : rem_sh;

  // Signed quotient; a zero span forces zero.
  assign q_mag    = $signed(FW'(dvd));
  assign q_signed = (span_r == '0) ? '0 : (neg ? -q_mag : q_mag);

  assign stat.busy      = (state != L_IDLE);
  assign stat.span_zero = span_zero;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (ctrl.start) begin
            diff     <= $signed({1'b0, raw_a}) - $signed({1'b0, offset});
            span_r   <= span;
            mirror_r <= ctrl.mirror;
            state    <= L_MUL;
          end
        end
        L_MUL: begin
          neg   <= diff[RAW_W];
          dvd   <= MAG_W'(diff_abs[RAW_W-1:0]) * MAG_W'(RES);
          rem   <= '0;
          cnt   <= CNT_W'(MAG_W - 1);
          state <= L_DIV;
        end
        L_DIV: begin
          rem <= rem_next;
          dvd <= {dvd[MAG_W-2:0], ge};
          if (cnt == '0) begin
            state <= L_FIX;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        L_FIX: begin
          fix       <= mirror_r ? (RES_F - q_signed) : q_signed;
          span_zero <= (span_r == '0);
          state     <= L_SAT;
        end
        L_SAT: begin
          if (fix > SAT_HI) begin
            value <= OUT_W'(SAT_HI);
          end else if (fix < SAT_LO) begin
            value <= OUT_W'(SAT_LO);
          end else begin
            value <= OUT_W'(fix);
          end
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the touch point calibration mapper.
`timescale 1ns / 1ps

module testbench;
  import tpcm_pkg::*;

  // Raw touch sample carried by one input transaction.
  typedef struct packed {
    logic             ok;
    logic [RAW_W-1:0] rx;
    logic [RAW_W-1:0] ry;
    logic             dn;
    logic             mv;
    logic             up;
  } sample_t;

  // Screen point carried by one output transaction.
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    pr;
    logic                    err;
  } point_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  // One line of the directed stimulus: a register write or a sample.
  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    sample_t                  smp;
    logic                     typed;
    point_t                   want;
  } dir_row_t;

  localparam int HRES            = HORIZ_RES_DEF;
  localparam int VRES            = VERT_RES_DEF;
  localparam int DIR_ROWS        = 39;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int ITEMS_PER_SETUP = 50;
  localparam int DRAIN_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT  = 2000;

  localparam logic signed [OUT_W-1:0] PT_MAX = OUT_W'(OUT_MAX);
  localparam logic signed [OUT_W-1:0] PT_MIN = OUT_W'(OUT_MIN);

  // Directed samples: reset state, pass-through extremes, flag combinations,
  // axis swap, mirroring, zero spans and saturation in both directions.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_SAMPLE, '0, '0, '{1'b0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{13'sd0, 13'sd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd4095, 12'd4095, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{PT_MAX, PT_MAX, 1'b1, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b1}, 1'b1,
      '{PT_MAX, PT_MAX, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{PT_MAX, PT_MAX, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd0, 12'd0, 1'b0, 1'b1, 1'b0}, 1'b1,
      '{13'sd0, 13'sd0, 1'b1, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd123, 12'd456, 1'b1, 1'b0, 1'b1}, 1'b1,
      '{13'sd123, 13'sd456, 1'b1, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b0, 12'd7, 12'd7, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{13'sd123, 13'sd456, 1'b1, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd2048, 12'd1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{13'sd2048, 13'sd1, 1'b1, 1'b0}},
    '{ROW_CFG, REG_CAL_ENABLE, 12'h001, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd4095, 12'd4095, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{13'sd480, 13'sd320, 1'b1, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd0, 12'd0, 1'b0, 1'b1, 1'b0}, 1'b1,
      '{13'sd0, 13'sd0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_SWAP_AXES, 12'h001, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd4095, 12'd0, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{13'sd0, 13'sd320, 1'b1, 1'b0}},
    '{ROW_CFG, REG_MIRROR_X, 12'hFFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_MIRROR_Y, 12'h001, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd4095, 12'd0, 1'b0, 1'b1, 1'b0}, 1'b1,
      '{13'sd480, 13'sd0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_SPAN_X, 12'h000, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd100, 12'd200, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b0, 12'd4095, 12'd4095, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{ROW_CFG, REG_SPAN_Y, 12'h000, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd5, 12'd5, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{13'sd480, 13'sd320, 1'b1, 1'b1}},
    '{ROW_CFG, REG_SPAN_X, 12'h001, '0, 1'b0, '0},
    '{ROW_CFG, REG_SPAN_Y, 12'h001, '0, 1'b0, '0},
    '{ROW_CFG, REG_OFFSET_X, 12'hFFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_OFFSET_Y, 12'hFFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_MIRROR_X, 12'h0FE, '0, 1'b0, '0},
    '{ROW_CFG, REG_MIRROR_Y, 12'h000, '0, 1'b0, '0},
    '{ROW_CFG, REG_SWAP_AXES, 12'h000, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd0, 12'd0, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{PT_MIN, PT_MIN, 1'b1, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd4095, 12'd4095, 1'b0, 1'b1, 1'b0}, 1'b1,
      '{13'sd0, 13'sd0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_OFFSET_X, 12'h000, '0, 1'b0, '0},
    '{ROW_CFG, REG_OFFSET_Y, 12'h000, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd4095, 12'd4095, 1'b0, 1'b1, 1'b0}, 1'b1,
      '{PT_MAX, PT_MAX, 1'b1, 1'b0}},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd1, 12'd1, 1'b0, 1'b1, 1'b0}, 1'b1,
      '{13'sd480, 13'sd320, 1'b1, 1'b0}},
    '{ROW_CFG, REG_MIRROR_X, 12'h001, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd4095, 12'd0, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{PT_MIN, 13'sd0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_CAL_ENABLE, 12'hFFE, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '{1'b1, 12'd4095, 12'd17, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{PT_MAX, 13'sd17, 1'b1, 1'b0}}
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   sample_ok = 1'b0;
  logic [RAW_W-1:0]       raw_x = '0;
  logic [RAW_W-1:0]       raw_y = '0;
  logic                   pen_down = 1'b0;
  logic                   pen_move = 1'b0;
  logic                   pen_up = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [OUT_W-1:0] screen_x;
  logic signed [OUT_W-1:0] screen_y;
  logic                   pressed;
  logic                   span_error;

  // Register copies and held state of the mapping, as seen by the testbench.
  logic             cal_on = 1'b0;
  logic             swap_on = 1'b0;
  logic             flip_x = 1'b0;
  logic             flip_y = 1'b0;
  logic [RAW_W-1:0] base_x = '0;
  logic [RAW_W-1:0] base_y = '0;
  logic [RAW_W-1:0] range_x = SPAN_RESET;
  logic [RAW_W-1:0] range_y = SPAN_RESET;
  logic signed [OUT_W-1:0] held_x = '0;
  logic signed [OUT_W-1:0] held_y = '0;
  logic             held_pressed = 1'b0;

  point_t pending_points [$];
  int     mismatch_count = 0;
  int     send_idle_pct = 9;
  int     recv_idle_pct = 75;
  int     quiet_cycles = 0;

  touch_point_calibrate_map dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_ok  (sample_ok),
    .raw_x      (raw_x),
    .raw_y      (raw_y),
    .pen_down   (pen_down),
    .pen_move   (pen_move),
    .pen_up     (pen_up),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .pressed    (pressed),
    .span_error (span_error)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Saturate a wide value to the signed screen coordinate range.
  function automatic logic signed [OUT_W-1:0] clamp_coord(input longint v);
    if (v > OUT_MAX) return PT_MAX;
    if (v < OUT_MIN) return PT_MIN;
    return OUT_W'(v);
  endfunction

  // Offset, scale by resolution over span (truncating), mirror, saturate.
  function automatic logic signed [OUT_W-1:0] scale_axis(
    input logic [RAW_W-1:0] raw, input logic [RAW_W-1:0] off,
    input logic [RAW_W-1:0] span, input int res, input logic mirror);
    longint delta;
    longint quot;
    delta = longint'(raw) - longint'(off);
    if (span == '0) quot = 0;
    else quot = (delta * res) / longint'(span);
    if (mirror) quot = res - quot;
    return clamp_coord(quot);
  endfunction

  // Advance the held point by one accepted sample and return the result.
  task automatic track_point(input sample_t s, output point_t p);
    logic [RAW_W-1:0] rx;
    logic [RAW_W-1:0] ry;
    logic [RAW_W-1:0] ax;
    logic [RAW_W-1:0] ay;
    rx = s.rx & RAW_MASK;
    ry = s.ry & RAW_MASK;
    p.err = 1'b0;
    if (s.ok && (s.dn || s.mv)) begin
      if (cal_on) begin
        ax = swap_on ? ry : rx;
        ay = swap_on ? rx : ry;
        held_x = scale_axis(ax, base_x, range_x, HRES, flip_x);
        held_y = scale_axis(ay, base_y, range_y, VRES, flip_y);
        p.err = (range_x == '0) || (range_y == '0);
      end else begin
        held_x = clamp_coord(longint'(rx));
        held_y = clamp_coord(longint'(ry));
      end
      held_pressed = 1'b1;
    end else if (s.ok && s.up) begin
      held_pressed = 1'b0;
    end
    p.x = held_x;
    p.y = held_y;
    p.pr = held_pressed;
  endtask

  // Present one sample, wait for its transaction and queue the expected point.
  // A write enable left high by back-to-back register writes is lowered here.
  task automatic send_sample(input sample_t s, input logic typed, input point_t typed_pt);
    point_t model_pt;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_ok <= s.ok;
    raw_x     <= s.rx;
    raw_y     <= s.ry;
    pen_down  <= s.dn;
    pen_move  <= s.mv;
    pen_up    <= s.up;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_point(s, model_pt);
    pending_points.push_back(typed ? typed_pt : model_pt);
    @(negedge clk);
  endtask

  // Write one register once every pending point has come out.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_CAL_ENABLE: cal_on  = data[0];
      REG_SWAP_AXES:  swap_on = data[0];
      REG_MIRROR_X:   flip_x  = data[0];
      REG_MIRROR_Y:   flip_y  = data[0];
      REG_OFFSET_X:   base_x  = data[RAW_W-1:0];
      REG_OFFSET_Y:   base_y  = data[RAW_W-1:0];
      REG_SPAN_X:     range_x = data[RAW_W-1:0];
      REG_SPAN_Y:     range_y = data[RAW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Raw reading with the extremes weighted up.
  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return RAW_W'($urandom_range(4095));
    endcase
  endfunction

  // Register word: the extremes now and then, otherwise from a typical range.
  function automatic logic [CFG_DATA_W-1:0] pick_word(input int lo, input int hi);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return CFG_DATA_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // One-bit register word with random junk in the ignored upper bits.
  function automatic logic [CFG_DATA_W-1:0] flag_word(input logic b);
    return {(CFG_DATA_W - 1)'($urandom), b};
  endfunction

  // Load a fresh random calibration into every register.
  task automatic load_random_setup();
    write_reg(REG_CAL_ENABLE, flag_word($urandom_range(4) != 0));
    write_reg(REG_SWAP_AXES, flag_word(1'($urandom_range(1))));
    write_reg(REG_MIRROR_X, flag_word(1'($urandom_range(1))));
    write_reg(REG_MIRROR_Y, flag_word(1'($urandom_range(1))));
    write_reg(REG_OFFSET_X, pick_word(0, 1500));
    write_reg(REG_OFFSET_Y, pick_word(0, 1500));
    write_reg(REG_SPAN_X, pick_word(1024, 4095));
    write_reg(REG_SPAN_Y, pick_word(1024, 4095));
  endtask

  // Receiver: random stall per the current idling phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each result transaction with the oldest pending point.
  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("result transaction with no sample pending");
        mismatch_count++;
      end else begin
        want = pending_points.pop_front();
        if (screen_x !== want.x) begin
          $error("screen_x expected %0d got %0d", $signed(want.x), screen_x);
          mismatch_count++;
        end
        if (screen_y !== want.y) begin
          $error("screen_y expected %0d got %0d", $signed(want.y), screen_y);
          mismatch_count++;
        end
        if (pressed !== want.pr) begin
          $error("pressed expected %0d got %0d", want.pr, pressed);
          mismatch_count++;
        end
        if (span_error !== want.err) begin
          $error("span_error expected %0d got %0d", want.err, span_error);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, then random touch gestures and noise samples
  // in three idling phases.
  initial begin : stimulus
    sample_t smp;
    int      ph;
    int      moves;
    int      phase_items;
    int      since_setup;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].data);
      end else begin
        send_sample(DIR_TABLE[i].smp, DIR_TABLE[i].typed, DIR_TABLE[i].want);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_items = 0;
      since_setup = ITEMS_PER_SETUP;
      while (phase_items < ITEMS_PER_PHASE) begin
        if (since_setup >= ITEMS_PER_SETUP) begin
          load_random_setup();
          since_setup = 0;
        end
        if ($urandom_range(4) != 0) begin
          // Well-formed gesture: down, a few moves, up; the odd sample dropped.
          moves = $urandom_range(6);
          for (int k = 0; k <= moves + 1; k++) begin
            smp.ok = ($urandom_range(15) != 0);
            smp.rx = pick_raw();
            smp.ry = pick_raw();
            smp.dn = (k == 0);
            smp.mv = (k != 0) && (k <= moves);
            smp.up = (k == moves + 1);
            send_sample(smp, 1'b0, '0);
            phase_items++;
            since_setup++;
          end
        end else begin
          // Noise: every field random.
          smp = sample_t'($bits(sample_t)'($urandom));
          send_sample(smp, 1'b0, '0);
          phase_items++;
          since_setup++;
        end
      end
    end

    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ touch_point_calibrate_map.f @@
sv/tpcm_pkg.sv
sv/tpcm_lane.sv
sv/touch_point_calibrate_map.sv
verif/testbench.sv
